>>> design/energy_activity_detector_core_defines.svh
// ----------------------------------------------------------------------------
// Energy activity detector - assertion macros
// Shared assertion shorthands; each expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef ENERGY_ACTIVITY_DETECTOR_CORE_DEFINES_SVH
`define ENERGY_ACTIVITY_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication
`define EAC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define EAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

>>> design/eac_pkg.sv
// ----------------------------------------------------------------------------
// Energy activity detector - package
// Types, constants and arithmetic helpers shared by the detector modules.
// ----------------------------------------------------------------------------
package eac_pkg;

  localparam int unsigned SCALE_SHIFT = 9;
  localparam int unsigned NUM_STAGES  = 8;

  localparam logic [30:0] ACC_MAX     = 31'h7FFF_FFFF;
  localparam logic [30:0] ACT_THRESH  = 31'd644245094;
  localparam logic [30:0] FLAG_THRESH = 31'd1073741824;

  localparam logic [4:0]  HPF_SHIFT_RST  = 5'd4;
  localparam logic [4:0]  LPF_SHIFT_RST  = 5'd6;
  localparam logic [4:0]  FP_SHIFT_RST   = 5'd10;
  localparam logic [15:0] DECIM_MASK_RST = 16'd255;
  localparam logic [7:0]  THR_GAIN_RST   = 8'd4;
  localparam logic [30:0] RISE_STEP_RST  = 31'd21474836;
  localparam logic [30:0] FALL_STEP_RST  = 31'd2147483;
  localparam logic [23:0] HOLD_RST       = 24'd16000;

  typedef enum logic [2:0] {
    CFG_HPF_SHIFT  = 3'd0,
    CFG_LPF_SHIFT  = 3'd1,
    CFG_FP_SHIFT   = 3'd2,
    CFG_DECIM_MASK = 3'd3,
    CFG_THR_GAIN   = 3'd4,
    CFG_RISE_STEP  = 3'd5,
    CFG_FALL_STEP  = 3'd6,
    CFG_HOLD       = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [4:0]  hpf_shift;
    logic [4:0]  lpf_shift;
    logic [4:0]  floor_peak_shift;
    logic [15:0] decim_mask;
    logic [7:0]  thr_gain;
    logic [30:0] rise_step;
    logic [30:0] fall_step;
    logic [23:0] hold_samples;
  } cfg_t;

  // One advance strobe per pipeline stage
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
    logic s7;
  } adv_t;

  function automatic logic [31:0] asr32(logic [31:0] x, logic [4:0] s);
    return 32'($signed(x) >>> s);
  endfunction

  // One-pole shift filter: acc + (in >> s) - (acc >> s)
  function automatic logic [31:0] smooth(logic [31:0] acc, logic [31:0] din,
                                         logic [4:0] s);
    return asr32(din, s) + acc - asr32(acc, s);
  endfunction

  function automatic logic [30:0] sat_add31(logic [30:0] a, logic [30:0] b);
    logic [31:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[31] ? ACC_MAX : sum[30:0];
  endfunction

  function automatic logic [30:0] sat_sub31(logic [30:0] a, logic [30:0] b);
    logic [31:0] dif;
    dif = {1'b0, a} - {1'b0, b};
    return dif[31] ? 31'd0 : dif[30:0];
  endfunction

endpackage

>>> design/eac_filter.sv
// ----------------------------------------------------------------------------
// Energy activity detector - filter stages
// High-pass difference and magnitude, envelope, peak and noise floor tracking.
// ----------------------------------------------------------------------------
`include "energy_activity_detector_core_defines.svh"

module eac_filter import eac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  adv_t        adv_i,
  input  logic [15:0] sample_i,
  output logic [31:0] peak_o,
  output logic [31:0] floor_o
);

  logic [31:0] hp_q, hp_d;
  logic [31:0] mag_q, mag_d;
  logic [31:0] env_q, env_d;
  logic [31:0] peak_q, peak_d;
  logic [31:0] floor_q, floor_d;
  logic [15:0] dcnt_q, dcnt_d;

  logic [31:0] x_scaled, hp_leak, diff;
  logic [31:0] peak_sm, floor_sm, floor_cl;
  logic [15:0] dcnt_dec;

  // Stage 1: leaky integrator and magnitude of its difference
  always_comb begin
    x_scaled = {{(16 - SCALE_SHIFT){sample_i[15]}}, sample_i, {SCALE_SHIFT{1'b0}}};
    hp_leak  = asr32(hp_q, cfg_i.hpf_shift);
    hp_d     = hp_q - hp_leak + x_scaled;
    diff     = x_scaled - hp_leak;
    mag_d    = diff[31] ? (32'd0 - diff) : diff;
  end

  // Stage 2: envelope
  assign env_d = smooth(env_q, mag_q, cfg_i.lpf_shift);

  // Stage 3: peak every item, floor once per decimation period
  always_comb begin
    peak_sm = smooth(peak_q, env_q, cfg_i.floor_peak_shift);
    peak_d  = ($signed(env_q) > $signed(peak_sm)) ? env_q : peak_sm;

    floor_sm = smooth(floor_q, env_q, cfg_i.floor_peak_shift);
    floor_cl = ($signed(env_q) < $signed(floor_sm)) ? env_q : floor_sm;
    dcnt_dec = cfg_i.decim_mask & (dcnt_q - 16'd1);
    if (dcnt_dec == 16'd0) begin
      floor_d = floor_cl[31] ? 32'd0 : floor_cl;
      dcnt_d  = cfg_i.decim_mask;
    end else begin
      floor_d = floor_q;
      dcnt_d  = dcnt_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q    <= '0;
      env_q   <= '0;
      peak_q  <= '0;
      floor_q <= '0;
      dcnt_q  <= '0;
    end else begin
      if (adv_i.s1) begin
        hp_q <= hp_d;
      end
      if (adv_i.s2) begin
        env_q <= env_d;
      end
      if (adv_i.s3) begin
        peak_q  <= peak_d;
        floor_q <= floor_d;
        dcnt_q  <= dcnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      mag_q <= mag_d;
    end
  end

  assign peak_o  = peak_q;
  assign floor_o = floor_q;

  `EAC_ASSERT_IMPLIES(a_floor_nonneg, 1'b1, !floor_q[31], "noise floor went negative")
  `EAC_ASSERT_NEXT(a_floor_hold, !adv_i.s3, $stable(floor_q) && $stable(peak_q),
                   "peak or floor moved without an item")

endmodule

>>> design/eac_decide.sv
// ----------------------------------------------------------------------------
// Energy activity detector - decision stages
// Threshold compare, activity and flag accumulators, onset hold counter.
// ----------------------------------------------------------------------------
`include "energy_activity_detector_core_defines.svh"

module eac_decide import eac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  adv_t        adv_i,
  input  logic [31:0] peak_i,
  input  logic [31:0] floor_i,
  output logic        detected_o
);

  logic        gt_q, gt_d;
  logic [30:0] act_q, act_d;
  logic [30:0] flag_q, flag_d;
  logic [23:0] hold_q, hold_d;
  logic        onset_q, onset_d;
  logic        det_q, det_d;

  logic signed [40:0] prod;
  logic signed [40:0] peak_ext;

  // Stage 4: peak against floor * gain at full width
  always_comb begin
    prod     = 41'($signed(floor_i)) * 41'($signed({1'b0, cfg_i.thr_gain}));
    peak_ext = 41'(signed'(peak_i));
    gt_d     = peak_ext > prod;
  end

  // Stage 5: activity accumulator
  assign act_d = gt_q ? sat_add31(act_q, cfg_i.rise_step)
                      : sat_sub31(act_q, cfg_i.fall_step);

  // Stage 6: flag accumulator, steps swapped
  assign flag_d = (act_q > ACT_THRESH) ? sat_add31(flag_q, cfg_i.fall_step)
                                       : sat_sub31(flag_q, cfg_i.rise_step);

  // Stage 7: hold counter, reload on a fresh onset
  always_comb begin
    hold_d  = hold_q;
    onset_d = onset_q;
    if (hold_q != 24'd0) begin
      hold_d = hold_q - 24'd1;
    end else begin
      onset_d = 1'b0;
    end
    if ((flag_q > FLAG_THRESH) && !onset_d) begin
      hold_d  = cfg_i.hold_samples;
      onset_d = 1'b1;
    end
    det_d = (hold_d != 24'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q   <= '0;
      flag_q  <= '0;
      hold_q  <= '0;
      onset_q <= 1'b0;
      det_q   <= 1'b0;
    end else begin
      if (adv_i.s5) begin
        act_q <= act_d;
      end
      if (adv_i.s6) begin
        flag_q <= flag_d;
      end
      if (adv_i.s7) begin
        hold_q  <= hold_d;
        onset_q <= onset_d;
        det_q   <= det_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s4) begin
      gt_q <= gt_d;
    end
  end

  assign detected_o = det_q;

  `EAC_ASSERT_IMPLIES(a_hold_onset, hold_q != 24'd0, onset_q,
                      "hold counter running without a latched onset")
  `EAC_ASSERT_IMPLIES(a_det_hold, 1'b1, det_q == (hold_q != 24'd0),
                      "detected disagrees with hold counter")

endmodule

>>> design/energy_activity_detector_core.sv
// ----------------------------------------------------------------------------
// Energy activity detector - top level
// Sample in, one activity decision out per sample.
// ----------------------------------------------------------------------------
// Takes one item per clock and returns one result item for each, in order,
// through the input register and seven stages, the last of which is the
// output register. Every stage keeps its own filter or accumulator state, so
// items follow back to back at one per cycle; the throughput is set by the
// single stalling pipeline: whenever the output item is held by out_ready_i
// low, the whole pipeline and in_ready_o halt.
// Write configuration only when no item is in flight.
`include "energy_activity_detector_core_defines.svh"

module energy_activity_detector_core import eac_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [30:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] sample_i,
  input  logic        end_of_block_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        detected_o,
  output logic        end_of_block_out_o
);

  cfg_t cfg_q;
  adv_t adv;

  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] eob_q;
  logic [15:0]           sample_q;
  logic                  en;
  logic [31:0]           peak, noise_floor;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hpf_shift        <= HPF_SHIFT_RST;
      cfg_q.lpf_shift        <= LPF_SHIFT_RST;
      cfg_q.floor_peak_shift <= FP_SHIFT_RST;
      cfg_q.decim_mask       <= DECIM_MASK_RST;
      cfg_q.thr_gain         <= THR_GAIN_RST;
      cfg_q.rise_step        <= RISE_STEP_RST;
      cfg_q.fall_step        <= FALL_STEP_RST;
      cfg_q.hold_samples     <= HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HPF_SHIFT:  cfg_q.hpf_shift        <= cfg_wdata_i[4:0];
        CFG_LPF_SHIFT:  cfg_q.lpf_shift        <= cfg_wdata_i[4:0];
        CFG_FP_SHIFT:   cfg_q.floor_peak_shift <= cfg_wdata_i[4:0];
        CFG_DECIM_MASK: cfg_q.decim_mask       <= cfg_wdata_i[15:0];
        CFG_THR_GAIN:   cfg_q.thr_gain         <= cfg_wdata_i[7:0];
        CFG_RISE_STEP:  cfg_q.rise_step        <= cfg_wdata_i;
        CFG_FALL_STEP:  cfg_q.fall_step        <= cfg_wdata_i;
        CFG_HOLD:       cfg_q.hold_samples     <= cfg_wdata_i[23:0];
        default: ;
      endcase
    end
  end

  // Advance everything unless the output item is stuck
  assign en         = !valid_q[NUM_STAGES-1] || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    adv.s1 = en && valid_q[0];
    adv.s2 = en && valid_q[1];
    adv.s3 = en && valid_q[2];
    adv.s4 = en && valid_q[3];
    adv.s5 = en && valid_q[4];
    adv.s6 = en && valid_q[5];
    adv.s7 = en && valid_q[6];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NUM_STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      eob_q <= {eob_q[NUM_STAGES-2:0], end_of_block_i};
      if (in_valid_i) begin
        sample_q <= sample_i;
      end
    end
  end

  eac_filter u_filter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .adv_i    (adv),
    .sample_i (sample_q),
    .peak_o   (peak),
    .floor_o  (noise_floor)
  );

  eac_decide u_decide (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .adv_i      (adv),
    .peak_i     (peak),
    .floor_i    (noise_floor),
    .detected_o (detected_o)
  );

  assign out_valid_o        = valid_q[NUM_STAGES-1];
  assign end_of_block_out_o = eob_q[NUM_STAGES-1];

  `EAC_ASSERT_NEXT(a_stall_freeze, out_valid_o && !out_ready_i, $stable(valid_q),
                   "pipeline moved while output stalled")
  `EAC_ASSERT_NEXT(a_accept_load, in_valid_i && in_ready_o, valid_q[0],
                   "accepted item did not enter the input register")

endmodule
